// ===== rtl/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants of the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

	localparam int RAM_BANK_BYTES = 8192;
	localparam int ROM_BANK_BYTES = 16384;
	localparam int RAM_OFF_W      = $clog2(RAM_BANK_BYTES);
	localparam int ROM_OFF_W      = $clog2(ROM_BANK_BYTES);
	localparam int ROM_SEL_W      = 5;
	localparam int ROM_ADDR_W     = ROM_SEL_W + ROM_OFF_W;
	localparam int RAM_SEL_W      = 2;
	localparam int RAM_CNT_W      = 3;
	localparam int RAM_IDX_MAX_W  = RAM_SEL_W + RAM_OFF_W;
	localparam int ADDR_W         = 16;
	localparam int BYTE_W         = 8;
	localparam int IN_TDATA_W     = 24;
	localparam int OUT_TDATA_W    = 32;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 5;

	localparam logic [3:0]        RAM_EN_KEY  = 4'hA;
	localparam logic [BYTE_W-1:0] OPEN_BUS    = 8'hFF;
	localparam logic [2:0]        RAM_REGION  = 3'b101;
	localparam logic              REQ_READ    = 1'b0;
	localparam logic              REQ_WRITE   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROM_MASK  = 2'd0,
		CFG_RAM_COUNT = 2'd1,
		CFG_HAS_RAM   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		REG_RAM_ENABLE = 2'd0,
		REG_ROM_BANK   = 2'd1,
		REG_RAM_BANK   = 2'd2,
		REG_MODE       = 2'd3
	} bank_reg_t;

	typedef struct packed {
		logic                  ram_read;
		logic                  ram_ok;
		logic                  rom_read;
		logic [ROM_ADDR_W-1:0] rom_address;
		logic                  fault;
	} dec_t;

	typedef struct packed {
		logic                     we;
		logic                     re;
		logic [RAM_IDX_MAX_W-1:0] idx;
		logic [BYTE_W-1:0]        wdata;
	} ram_req_t;

endpackage

// ===== rtl/cbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbc_ctrl
// Configuration and bank registers, address decode and RAM request forming.
// ----------------------------------------------------------------------------
module cbc_ctrl #(
	parameter int RAM_BANKS     = 4,
	parameter int ROM_BANK_BITS = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr,
	input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           acc,
	input  logic                           req_type,
	input  logic [cbc_pkg::ADDR_W-1:0]     address,
	input  logic [cbc_pkg::BYTE_W-1:0]     write_data,
	output cbc_pkg::dec_t                  dec,
	output cbc_pkg::ram_req_t              ram_req
);
	import cbc_pkg::*;

	logic [ROM_SEL_W-1:0]     rom_mask_q;
	logic [RAM_CNT_W-1:0]     ram_cnt_q;
	logic                     has_ram_q;
	logic                     ram_en_q;
	logic [ROM_BANK_BITS-1:0] rom_sel_q;
	logic [RAM_SEL_W-1:0]     ram_sel_q;
	logic                     mode_q;

	logic                     is_wr;
	logic                     in_rom;
	logic                     in_ram;
	logic [RAM_SEL_W-1:0]     eff_bank;
	logic                     ram_ok;
	logic [ROM_BANK_BITS-1:0] sel_nz;
	logic [ROM_SEL_W-1:0]     rom_bank;
	logic [RAM_SEL_W-1:0]     new_ram_sel;

	always_comb begin
		is_wr       = (req_type == REQ_WRITE);
		in_rom      = ~address[ADDR_W-1];
		in_ram      = (address[ADDR_W-1 -: 3] == RAM_REGION);
		eff_bank    = mode_q ? ram_sel_q : '0;
		ram_ok      = has_ram_q && ram_en_q
			&& ({1'b0, eff_bank} < ram_cnt_q)
			&& ({1'b0, eff_bank} < RAM_CNT_W'(RAM_BANKS));
		sel_nz      = (rom_sel_q == '0) ? ROM_BANK_BITS'(1) : rom_sel_q;
		rom_bank    = ROM_SEL_W'(sel_nz) & rom_mask_q;
		new_ram_sel = write_data[RAM_SEL_W-1:0];

		dec.fault       = !in_rom && !in_ram;
		dec.rom_read    = in_rom && !is_wr;
		dec.ram_read    = in_ram && !is_wr;
		dec.ram_ok      = ram_ok;
		if (!dec.rom_read) begin
			dec.rom_address = '0;
		end else if (address[ROM_OFF_W]) begin
			dec.rom_address = {rom_bank, address[ROM_OFF_W-1:0]};
		end else begin
			dec.rom_address = {{ROM_SEL_W{1'b0}}, address[ROM_OFF_W-1:0]};
		end

		ram_req.re    = acc && in_ram && !is_wr && ram_ok;
		ram_req.we    = acc && in_ram && is_wr && ram_ok;
		ram_req.idx   = {eff_bank, address[RAM_OFF_W-1:0]};
		ram_req.wdata = write_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_mask_q <= '1;
			ram_cnt_q  <= RAM_CNT_W'(4);
			has_ram_q  <= 1'b1;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_ROM_MASK:  rom_mask_q <= cfg_data[ROM_SEL_W-1:0];
				CFG_RAM_COUNT: ram_cnt_q  <= cfg_data[RAM_CNT_W-1:0];
				CFG_HAS_RAM:   has_ram_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_en_q  <= 1'b0;
			rom_sel_q <= ROM_BANK_BITS'(1);
			ram_sel_q <= '0;
			mode_q    <= 1'b0;
		end else if (acc && in_rom && is_wr) begin
			unique case (bank_reg_t'(address[ROM_OFF_W:ROM_OFF_W-1]))
				REG_RAM_ENABLE: ram_en_q <= (write_data[3:0] == RAM_EN_KEY);
				REG_ROM_BANK:   rom_sel_q <= write_data[ROM_BANK_BITS-1:0];
				REG_RAM_BANK: begin
					if ({1'b0, new_ram_sel} < ram_cnt_q) begin
						ram_sel_q <= new_ram_sel;
					end
				end
				REG_MODE:       mode_q <= write_data[0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/cbc_ram.sv =====
// ----------------------------------------------------------------------------
// cbc_ram
// Cartridge RAM: single-port synchronous array with a clearing sweep after
// reset.
// ----------------------------------------------------------------------------
module cbc_ram #(
	parameter int RAM_BANKS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cbc_pkg::ram_req_t          ram_req,
	output logic                       busy,
	output logic [cbc_pkg::BYTE_W-1:0] rdata
);
	import cbc_pkg::*;

	localparam int DEPTH = RAM_BANKS * RAM_BANK_BYTES;
	localparam int IDX_W = $clog2(DEPTH);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic              clearing_q;
	logic [IDX_W-1:0]  clr_cnt_q;
	logic [IDX_W-1:0]  idx;

	assign busy = clearing_q;
	assign idx  = ram_req.idx[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + IDX_W'(1);
			if (clr_cnt_q == IDX_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (ram_req.we) begin
			mem[idx] <= ram_req.wdata;
		end
		if (ram_req.re) begin
			rdata <= mem[idx];
		end
	end

endmodule

// ===== rtl/cartridge_bank_controller_core.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_controller_core
// Bank controller of a game cartridge: bus access decode, bank registers and
// banked cartridge RAM.
// path: an accepted request passes the stage-1 register (RAM read), then the output reg
// throughput: one request per cycle, set by the single RAM port, while m_tready holds and the RAM is not clearing
// reset: control registers reset at once; then the RAM is cleared one byte
// per cycle, over all RAM_BANKS * 8192 bytes, while s_tready stays low
// ----------------------------------------------------------------------------
module cartridge_bank_controller_core #(
	parameter int RAM_BANKS     = 4,
	parameter int ROM_BANK_BITS = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cbc_pkg::IN_TDATA_W-1:0]  s_tdata,   // address, write_data
	input  logic                            s_tuser,   // req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cbc_pkg::OUT_TDATA_W-1:0] m_tdata,   // read_data, rom_read, rom_address, fault
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cbc_pkg::*;

	localparam int OUT_FIELDS_W = BYTE_W + 1 + ROM_ADDR_W + 1;

	dec_t                   dec;
	ram_req_t               ram_req;
	logic                   busy;
	logic [BYTE_W-1:0]      rdata;
	logic                   accept;
	logic                   move;
	logic                   valid_s1;
	dec_t                   dec_s1;
	logic [BYTE_W-1:0]      read_data_s1;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	assign cfg_ready = 1'b1;
	assign move      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !busy && (!valid_s1 || move);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	cbc_ctrl #(
		.RAM_BANKS    (RAM_BANKS),
		.ROM_BANK_BITS(ROM_BANK_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (accept),
		.req_type  (s_tuser),
		.address   (s_tdata[ADDR_W-1:0]),
		.write_data(s_tdata[ADDR_W +: BYTE_W]),
		.dec       (dec),
		.ram_req   (ram_req)
	);

	cbc_ram #(
		.RAM_BANKS(RAM_BANKS)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.ram_req(ram_req),
		.busy   (busy),
		.rdata  (rdata)
	);

	always_comb begin
		if (!dec_s1.ram_read) begin
			read_data_s1 = '0;
		end else if (dec_s1.ram_ok) begin
			read_data_s1 = rdata;
		end else begin
			read_data_s1 = OPEN_BUS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1 <= dec;
		end
		if (move) begin
			out_data_q <= {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, dec_s1.fault,
				dec_s1.rom_address, dec_s1.rom_read, read_data_s1};
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the cartridge bank controller. Directed bus accesses
// cover the ROM and RAM windows, the bank registers, RAM gating and unmapped
// addresses. Random accesses then run under several bank-mask, RAM-count and
// RAM-present settings while both stream sides idle at random. A built-in
// predictor keeps its own copy of the registers and cartridge RAM and checks
// every response field against it in order.
// ----------------------------------------------------------------------------
module tb_top;
	import cbc_pkg::*;

	localparam int CYCLE        = 10;
	localparam int RAM_BANK_NUM = 4;
	localparam int ROM_BITS     = 5;
	localparam int RAM_BYTES    = RAM_BANK_NUM * RAM_BANK_BYTES;
	localparam int SETTLE       = 8;
	localparam int PHASES       = 10;
	localparam int PHASE_ITEMS  = 185;

	typedef struct packed {
		logic              req_type;
		logic [ADDR_W-1:0] address;
		logic [BYTE_W-1:0] write_data;
	} bus_access_t;

	typedef struct packed {
		logic [2:0]            pad;
		logic                  fault;
		logic [ROM_ADDR_W-1:0] rom_address;
		logic                  rom_read;
		logic [BYTE_W-1:0]     read_data;
	} bus_result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// predictor state
	logic [ROM_SEL_W-1:0] bank_mask;
	logic [RAM_CNT_W-1:0] ram_banks_present;
	logic                 ram_fitted;
	logic                 ram_enabled;
	logic [ROM_SEL_W-1:0] rom_bank;
	logic [RAM_SEL_W-1:0] ram_bank;
	logic                 mode_sel;
	logic [BYTE_W-1:0]    cart_ram_shadow [0:RAM_BYTES-1];

	bus_access_t bus_queue[$];
	bus_result_t expected_results[$];
	bus_access_t cur_access;

	int queued_count   = 0;
	int accepted_count = 0;
	int checked_count  = 0;
	int mismatch_count = 0;
	int rom_reads      = 0;
	int ram_hits       = 0;
	int ram_blocked    = 0;
	int faults         = 0;
	int settings       = 0;
	int gap_left       = 0;
	int stall_left     = 0;
	bit src_calm       = 1'b0;
	bit sink_calm      = 1'b0;

	cartridge_bank_controller_core #(
		.RAM_BANKS    (RAM_BANK_NUM),
		.ROM_BANK_BITS(ROM_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#(CYCLE / 2) clk = 1'b1;
		#(CYCLE / 2) clk = 1'b0;
	end

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic bus_result_t predict_bus_access(input bus_access_t acc);
		bus_result_t            res;
		logic [RAM_SEL_W-1:0]   eff_bank;
		logic [ROM_SEL_W-1:0]   sel;
		logic [RAM_IDX_MAX_W-1:0] idx;
		logic                   ram_ok;
		res = '0;
		if (acc.address[ADDR_W-1] == 1'b0) begin
			if (acc.req_type == REQ_WRITE) begin
				case (bank_reg_t'(acc.address[14:13]))
					REG_RAM_ENABLE: ram_enabled = (acc.write_data[3:0] == RAM_EN_KEY);
					REG_ROM_BANK:   rom_bank = acc.write_data[ROM_SEL_W-1:0];
					REG_RAM_BANK: begin
						if ({1'b0, acc.write_data[RAM_SEL_W-1:0]} < ram_banks_present)
							ram_bank = acc.write_data[RAM_SEL_W-1:0];
					end
					default: mode_sel = acc.write_data[0];
				endcase
			end else begin
				res.rom_read = 1'b1;
				rom_reads++;
				if (acc.address[14] == 1'b0) begin
					res.rom_address = ROM_ADDR_W'(acc.address);
				end else begin
					sel = (rom_bank == '0) ? ROM_SEL_W'(1) : rom_bank;
					sel = sel & bank_mask;
					res.rom_address = {sel, acc.address[ROM_OFF_W-1:0]};
				end
			end
		end else if (acc.address[15:13] == RAM_REGION) begin
			eff_bank = mode_sel ? ram_bank : '0;
			ram_ok = ram_fitted && ram_enabled && ({1'b0, eff_bank} < ram_banks_present)
				&& (int'(eff_bank) < RAM_BANK_NUM);
			idx = {eff_bank, acc.address[RAM_OFF_W-1:0]};
			if (ram_ok) ram_hits++;
			else ram_blocked++;
			if (acc.req_type == REQ_WRITE) begin
				if (ram_ok) cart_ram_shadow[idx] = acc.write_data;
			end else begin
				res.read_data = ram_ok ? cart_ram_shadow[idx] : OPEN_BUS;
			end
		end else begin
			res.fault = 1'b1;
			faults++;
		end
		return res;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(predict_bus_access(cur_access));
				accepted_count++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (bus_queue.size() > 0) begin
					cur_access = bus_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {cur_access.write_data, cur_access.address};
					s_tuser  <= cur_access.req_type;
					if ($urandom_range(0, 63) == 0) src_calm = !src_calm;
					gap_left = (src_calm || $urandom_range(0, 1) == 0) ? 0 : pick_len();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// response sink with random stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 99) == 0) sink_calm = !sink_calm;
				if (!sink_calm && $urandom_range(0, 99) < 25) stall_left = pick_len();
			end
		end
	end

	task automatic check_field(input string name, input int unsigned exp_v,
		input int unsigned got_v);
		if (exp_v != got_v) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("response %0d: %s expected 0x%0h got 0x%0h",
					checked_count, name, exp_v, got_v);
		end
	endtask

	// response monitor
	always @(posedge clk) begin
		bus_result_t got;
		bus_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got = bus_result_t'(m_tdata);
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("response with nothing outstanding: 0x%0h", m_tdata);
			end else begin
				exp_r = expected_results.pop_front();
				check_field("read_data", 32'(exp_r.read_data), 32'(got.read_data));
				check_field("rom_read", 32'(exp_r.rom_read), 32'(got.rom_read));
				check_field("rom_address", 32'(exp_r.rom_address), 32'(got.rom_address));
				check_field("fault", 32'(exp_r.fault), 32'(got.fault));
			end
			checked_count++;
		end
	end

	task automatic add_access(input logic rt, input logic [ADDR_W-1:0] addr,
		input logic [BYTE_W-1:0] data);
		bus_access_t acc;
		acc.req_type   = rt;
		acc.address    = addr;
		acc.write_data = data;
		bus_queue.push_back(acc);
		queued_count++;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (accepted_count != queued_count || expected_results.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ROM_MASK:  bank_mask = val[ROM_SEL_W-1:0];
			CFG_RAM_COUNT: ram_banks_present = val[RAM_CNT_W-1:0];
			default:       ram_fitted = val[0];
		endcase
	endtask

	initial begin
		int r;
		int plan [0:PHASES-1][0:2];
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
		logic rt;

		bank_mask         = 5'd31;
		ram_banks_present = 3'd4;
		ram_fitted        = 1'b1;
		ram_enabled       = 1'b0;
		rom_bank          = 5'd1;
		ram_bank          = '0;
		mode_sel          = 1'b0;
		foreach (cart_ram_shadow[i]) cart_ram_shadow[i] = '0;
		plan = '{'{31, 4, 1}, '{0, 0, 0}, '{15, 2, 1}, '{1, 1, 1}, '{31, 3, 1},
			'{7, 4, 0}, '{0, 4, 1}, '{31, 0, 1}, '{-1, -1, -1}, '{31, 4, 1}};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under reset settings
		add_access(REQ_READ, 16'h0000, 8'h00);
		add_access(REQ_READ, 16'h3FFF, 8'hFF);
		add_access(REQ_READ, 16'h4000, 8'h00);
		add_access(REQ_READ, 16'h7FFF, 8'h00);
		add_access(REQ_READ, 16'hA000, 8'h00);
		add_access(REQ_WRITE, 16'hA000, 8'h77);
		add_access(REQ_WRITE, 16'h0000, 8'h0A);
		add_access(REQ_WRITE, 16'hA000, 8'h5A);
		add_access(REQ_READ, 16'hA000, 8'h00);
		add_access(REQ_READ, 16'hBFFF, 8'h00);
		add_access(REQ_WRITE, 16'h2000, 8'h00);
		add_access(REQ_READ, 16'h4000, 8'h00);
		add_access(REQ_WRITE, 16'h3FFF, 8'hFF);
		add_access(REQ_READ, 16'h7FFF, 8'h00);
		add_access(REQ_WRITE, 16'h4000, 8'h03);
		add_access(REQ_WRITE, 16'h6000, 8'h01);
		add_access(REQ_WRITE, 16'hBFFF, 8'hA5);
		add_access(REQ_READ, 16'hBFFF, 8'h00);
		add_access(REQ_WRITE, 16'h7FFF, 8'hFE);
		add_access(REQ_READ, 16'hBFFF, 8'h00);
		add_access(REQ_READ, 16'h8000, 8'h00);
		add_access(REQ_WRITE, 16'h9FFF, 8'hFF);
		add_access(REQ_READ, 16'hC000, 8'h00);
		add_access(REQ_WRITE, 16'hFFFF, 8'h12);
		add_access(REQ_WRITE, 16'h1FFF, 8'hFB);
		add_access(REQ_READ, 16'hA000, 8'h00);
		wait_idle();

		for (int ph = 0; ph < PHASES; ph++) begin
			write_cfg(CFG_ROM_MASK, (plan[ph][0] < 0) ? 5'($urandom_range(0, 31))
				: 5'(plan[ph][0]));
			write_cfg(CFG_RAM_COUNT, (plan[ph][1] < 0) ? 5'($urandom_range(0, 4))
				: 5'(plan[ph][1]));
			write_cfg(CFG_HAS_RAM, (plan[ph][2] < 0) ? 5'($urandom_range(0, 1))
				: 5'(plan[ph][2]));
			settings++;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r    = $urandom_range(0, 99);
				data = 8'($urandom);
				rt   = 1'($urandom);
				if (r < 25) begin
					// rom window read
					rt = REQ_READ;
					case ($urandom_range(0, 4))
						0:       addr = 16'h3FFF;
						1:       addr = 16'h4000;
						default: addr = {1'b0, 15'($urandom)};
					endcase
				end else if (r < 55) begin
					// ram window, offsets clustered so reads find earlier writes
					case ($urandom_range(0, 9))
						0, 1, 2, 3: addr = 16'hA000 | 16'($urandom_range(0, 15));
						4:          addr = 16'hA000;
						5:          addr = 16'hBFFF;
						default:    addr = {RAM_REGION, 13'($urandom)};
					endcase
				end else if (r < 80) begin
					// bank register write
					rt   = REQ_WRITE;
					addr = {1'b0, 2'($urandom), 13'($urandom)};
					if (addr[14:13] == REG_RAM_ENABLE && $urandom_range(0, 9) < 7)
						data[3:0] = RAM_EN_KEY;
				end else if (r < 90) begin
					addr = ($urandom_range(0, 1) == 0) ? {3'b100, 13'($urandom)}
						: {2'b11, 14'($urandom)};
				end else begin
					addr = 16'($urandom);
				end
				add_access(rt, addr, data);
			end
			wait_idle();
		end

		$display("checked %0d responses over %0d settings: %0d rom reads, %0d faults",
			checked_count, settings, rom_reads, faults);
		$display("ram window: %0d reached the array, %0d gated off", ram_hits, ram_blocked);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d responses outstanding", mismatch_count,
				expected_results.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#(CYCLE * 3000000);
		$display("timeout with %0d responses outstanding", expected_results.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
